// ===== sv/casu_pkg.sv =====
// Shared types and constants for the contrast autofocus sweep unit.
// No dependencies; imported by casu_core and the top level.
package casu_pkg;

	localparam int CFG_IDX_W     = 3;
	localparam int COARSE_W      = 10;
	localparam int FINE_STRIDE_W = 8;
	localparam int FINE_COUNT_W  = 7;
	localparam int SETTLE_W      = 4;
	localparam int RECHECK_W     = 8;
	localparam int DROP_W        = 7;
	localparam int AGE_W         = 8;

	localparam int POS_LOWEST_RST  = 0;
	localparam int POS_HIGHEST_RST = 1023;
	localparam int COARSE_RST      = 64;
	localparam int FINE_STRIDE_RST = 8;
	localparam int FINE_COUNT_RST  = 8;
	localparam int SETTLE_RST      = 3;
	localparam int RECHECK_RST     = 30;
	localparam int DROP_RST        = 70;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POS_LOWEST     = 3'd0,
		REG_POS_HIGHEST    = 3'd1,
		REG_COARSE_STRIDE  = 3'd2,
		REG_FINE_STRIDE    = 3'd3,
		REG_FINE_COUNT     = 3'd4,
		REG_SETTLE_WAIT    = 3'd5,
		REG_RECHECK_PERIOD = 3'd6,
		REG_DROP_PERCENT   = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OFF      = 2'd0,
		ST_OVERRIDE = 2'd1,
		ST_LOCKED   = 2'd2,
		ST_SEARCH   = 2'd3
	} af_status_t;

endpackage

// ===== sv/casu_if.sv =====
// Channel interfaces of the contrast autofocus sweep unit: item input,
// result output and configuration write. No dependencies.
interface casu_in_if #(parameter int POS_BITS = 10, parameter int SHARP_BITS = 32);
	logic                  valid;
	logic                  ready;
	logic                  af_enable;
	logic                  manual_hold;
	logic                  stat_new;
	logic [SHARP_BITS-1:0] sharpness;
	logic [POS_BITS-1:0]   lens_now;

	modport source(output valid, af_enable, manual_hold, stat_new, sharpness, lens_now,
		input ready);
	modport sink(input valid, af_enable, manual_hold, stat_new, sharpness, lens_now,
		output ready);
endinterface

interface casu_out_if #(parameter int POS_BITS = 10, parameter int SHARP_BITS = 32);
	logic                  valid;
	logic                  ready;
	logic [POS_BITS-1:0]   lens_target;
	logic                  lens_move;
	logic [1:0]            af_status;
	logic [SHARP_BITS-1:0] shown_sharpness;

	modport source(output valid, lens_target, lens_move, af_status, shown_sharpness,
		input ready);
	modport sink(input valid, lens_target, lens_move, af_status, shown_sharpness,
		output ready);
endinterface

interface casu_cfg_if #(parameter int IDX_W = 3, parameter int DATA_W = 10);
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/casu_out_buf.sv =====
// Two-entry result buffer that decouples the sweep core from the result sink.
// Depends on nothing but its parameter.
module casu_out_buf #(
	parameter int W = 45
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         push_ready,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);
	localparam int DEPTH = 2;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic             wr_q;
	logic             rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign out_valid  = (cnt_q != '0);
	assign out_data   = mem_q[rd_q];
	assign pop        = out_valid & out_ready;

	// data entries need no reset; the count guards them
	always_ff @(posedge clk) begin
		if (push && push_ready)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push && push_ready)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			if ((push && push_ready) && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (!(push && push_ready) && pop)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end
endmodule

// ===== sv/casu_core.sv =====
// Sweep core, using casu_pkg and the channel interfaces: configuration and input
// registers and autofocus state update, one item per cycle unless stalled.
module casu_core
	import casu_pkg::*;
#(
	parameter int POS_BITS   = 10,
	parameter int SHARP_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	casu_in_if.sink               item_in,
	casu_cfg_if.sink              cfg,
	output logic                  res_push,
	input  logic                  buf_ready,
	output logic [POS_BITS-1:0]   res_target,
	output logic                  res_move,
	output af_status_t            res_status,
	output logic [SHARP_BITS-1:0] res_shown
);
	localparam int NP_W   = ((POS_BITS > COARSE_W) ? POS_BITS : COARSE_W) + 1;
	localparam int HALF_W = FINE_STRIDE_W + FINE_COUNT_W - 1;
	localparam int LOW_W  = ((POS_BITS > HALF_W) ? POS_BITS : HALF_W) + 1;
	localparam int SPAN_W = FINE_STRIDE_W + FINE_COUNT_W;
	localparam int END_W  = ((POS_BITS > SPAN_W) ? POS_BITS : SPAN_W) + 1;
	localparam int PROD_W = SHARP_BITS + DROP_W;

	typedef enum logic [2:0] {
		M_IDLE, M_COARSE, M_FINE, M_LOCKED, M_OVERRIDE
	} mode_t;

	// configuration
	logic [POS_BITS-1:0]      pos_lowest_q, pos_highest_q;
	logic [COARSE_W-1:0]      coarse_stride_q;
	logic [FINE_STRIDE_W-1:0] fine_stride_q;
	logic [FINE_COUNT_W-1:0]  fine_count_q;
	logic [SETTLE_W-1:0]      settle_wait_q;
	logic [RECHECK_W-1:0]     recheck_q;
	logic [DROP_W-1:0]        drop_q;

	// input register
	logic                  v_s1;
	logic                  en_s1, hold_s1, stat_s1;
	logic [SHARP_BITS-1:0] sharp_s1;
	logic [POS_BITS-1:0]   lens_s1;
	logic [PROD_W-1:0]     x100_s1;

	// sweep state
	mode_t                 mode_q, mode_n;
	logic                  en_seen_q, en_seen_n;
	logic [SETTLE_W-1:0]   settle_q, settle_n;
	logic [SHARP_BITS-1:0] best_sharp_q, best_sharp_n;
	logic [POS_BITS-1:0]   best_lens_q, best_lens_n;
	logic [POS_BITS-1:0]   fine_start_q, fine_start_n;
	logic [SHARP_BITS-1:0] lock_sharp_q, lock_sharp_n;
	logic [PROD_W-1:0]     lock_prod_q;
	logic [AGE_W-1:0]      lock_age_q, lock_age_n, age_inc;
	logic [SHARP_BITS-1:0] last_q, last_n;

	logic                  adv, stat_v, go, lock_load, cfg_drop;
	logic [POS_BITS-1:0]   next_pos, ws_cur;
	logic [HALF_W-1:0]     half;
	logic [SPAN_W-1:0]     span;
	logic [NP_W-1:0]       np_c, np_f;
	logic [END_W-1:0]      fine_end;
	logic [SHARP_BITS:0]   sharp_inc;
	logic [PROD_W-1:0]     x100_in, mul_a, mul_b, mul_p;

	function automatic logic [POS_BITS-1:0] clamp_pos(
		input logic [POS_BITS-1:0] p,
		input logic [POS_BITS-1:0] lo,
		input logic [POS_BITS-1:0] hi
	);
		logic [POS_BITS-1:0] r;
		r = (p < lo) ? lo : p;
		return (r > hi) ? hi : r;
	endfunction

	// window start, never below the low limit
	function automatic logic [POS_BITS-1:0] window_start(
		input logic [POS_BITS-1:0] centre,
		input logic [HALF_W-1:0]   hw,
		input logic [POS_BITS-1:0] lo
	);
		if (LOW_W'(centre) >= LOW_W'(hw) + LOW_W'(lo))
			return POS_BITS'(LOW_W'(centre) - LOW_W'(hw));
		return lo;
	endfunction

	assign adv           = v_s1 & buf_ready;
	assign item_in.ready = ~v_s1 | adv;
	assign cfg.ready     = 1'b1;
	assign cfg_drop      = cfg.valid && (cfg_reg_t'(cfg.index) == REG_DROP_PERCENT);

	// 100 * (sharpness + 1), compared against lock_sharp * drop_percent
	assign sharp_inc = {1'b0, item_in.sharpness} + (SHARP_BITS + 1)'(1);
	assign x100_in   = (PROD_W'(sharp_inc) << 6) + (PROD_W'(sharp_inc) << 5)
		+ (PROD_W'(sharp_inc) << 2);

	assign half     = HALF_W'(fine_stride_q) * HALF_W'(fine_count_q >> 1);
	assign span     = SPAN_W'(fine_stride_q) * SPAN_W'(fine_count_q);
	assign fine_end = END_W'(fine_start_q) + END_W'(span);
	assign np_c     = NP_W'(lens_s1) + NP_W'(coarse_stride_q);
	assign np_f     = NP_W'(lens_s1) + NP_W'(fine_stride_q);
	assign ws_cur   = window_start(lens_s1, half, pos_lowest_q);
	assign age_inc  = (lock_age_q == '1) ? lock_age_q : lock_age_q + AGE_W'(1);

	// one multiplier, shared by the lock transition and a drop_percent write
	assign mul_a = adv ? PROD_W'(best_sharp_n) : PROD_W'(lock_sharp_q);
	assign mul_b = adv ? PROD_W'(drop_q) : PROD_W'(cfg.data[DROP_W-1:0]);
	assign mul_p = mul_a * mul_b;

	always_comb begin
		mode_n       = mode_q;
		en_seen_n    = en_seen_q;
		settle_n     = settle_q;
		best_sharp_n = best_sharp_q;
		best_lens_n  = best_lens_q;
		fine_start_n = fine_start_q;
		lock_sharp_n = lock_sharp_q;
		lock_age_n   = lock_age_q;
		last_n       = last_q;
		lock_load    = 1'b0;
		stat_v       = stat_s1;
		go           = 1'b0;
		next_pos     = lens_s1;
		res_target   = clamp_pos(lens_s1, pos_lowest_q, pos_highest_q);
		res_move     = 1'b0;

		if (en_s1 != en_seen_q) begin
			en_seen_n = en_s1;
			if (en_s1) begin
				mode_n       = M_COARSE;
				best_sharp_n = '0;
				best_lens_n  = '0;
				settle_n     = settle_wait_q;
				stat_v       = 1'b0;
			end else begin
				mode_n = M_IDLE;
			end
		end

		if (!en_s1) begin
			mode_n = M_IDLE;
		end else if (hold_s1) begin
			mode_n = M_OVERRIDE;
		end else if (mode_n == M_OVERRIDE) begin
			mode_n       = M_FINE;
			best_sharp_n = '0;
			best_lens_n  = lens_s1;
			fine_start_n = ws_cur;
			settle_n     = settle_wait_q;
			res_target   = clamp_pos(ws_cur, pos_lowest_q, pos_highest_q);
			res_move     = 1'b1;
		end else if (stat_v) begin
			if (settle_n != '0) begin
				settle_n = settle_n - SETTLE_W'(1);
			end else begin
				last_n = sharp_s1;
				if (sharp_s1 > best_sharp_n) begin
					best_sharp_n = sharp_s1;
					best_lens_n  = lens_s1;
				end
				case (mode_n)
					M_COARSE: begin
						go = 1'b1;
						if (np_c > NP_W'(pos_highest_q)) begin
							// fine window around the coarse peak just updated above
							fine_start_n = window_start(best_lens_n, half, pos_lowest_q);
							next_pos     = fine_start_n;
							mode_n       = M_FINE;
							best_sharp_n = '0;
							best_lens_n  = fine_start_n;
						end else begin
							next_pos = POS_BITS'(np_c);
						end
					end
					M_FINE: begin
						go = 1'b1;
						if (END_W'(np_f) > fine_end || np_f > NP_W'(pos_highest_q)) begin
							next_pos     = best_lens_n;
							mode_n       = M_LOCKED;
							lock_sharp_n = best_sharp_n;
							lock_load    = 1'b1;
							lock_age_n   = '0;
						end else begin
							next_pos = POS_BITS'(np_f);
						end
					end
					M_LOCKED: begin
						lock_age_n = age_inc;
						if (age_inc >= recheck_q) begin
							if (x100_s1 <= lock_prod_q) begin
								mode_n       = M_COARSE;
								best_sharp_n = '0;
								best_lens_n  = lens_s1;
								settle_n     = '0;
							end else begin
								lock_age_n = '0;
							end
						end
					end
					default: ;
				endcase
				if (go && next_pos != lens_s1) begin
					res_target = clamp_pos(next_pos, pos_lowest_q, pos_highest_q);
					res_move   = 1'b1;
					settle_n   = settle_wait_q;
				end
			end
		end

		if (!en_s1)
			res_status = ST_OFF;
		else if (hold_s1)
			res_status = ST_OVERRIDE;
		else if (mode_n == M_LOCKED)
			res_status = ST_LOCKED;
		else if (mode_n == M_IDLE)
			res_status = ST_OFF;
		else
			res_status = ST_SEARCH;
	end

	assign res_push  = adv;
	assign res_shown = last_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_lowest_q    <= POS_BITS'(POS_LOWEST_RST);
			pos_highest_q   <= POS_BITS'(POS_HIGHEST_RST);
			coarse_stride_q <= COARSE_W'(COARSE_RST);
			fine_stride_q   <= FINE_STRIDE_W'(FINE_STRIDE_RST);
			fine_count_q    <= FINE_COUNT_W'(FINE_COUNT_RST);
			settle_wait_q   <= SETTLE_W'(SETTLE_RST);
			recheck_q       <= RECHECK_W'(RECHECK_RST);
			drop_q          <= DROP_W'(DROP_RST);
			v_s1            <= 1'b0;
			en_s1           <= 1'b0;
			hold_s1         <= 1'b0;
			stat_s1         <= 1'b0;
			sharp_s1        <= '0;
			lens_s1         <= '0;
			x100_s1         <= '0;
			mode_q          <= M_IDLE;
			en_seen_q       <= 1'b0;
			settle_q        <= '0;
			best_sharp_q    <= '0;
			best_lens_q     <= '0;
			fine_start_q    <= '0;
			lock_sharp_q    <= '0;
			lock_prod_q     <= '0;
			lock_age_q      <= '0;
			last_q          <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg_reg_t'(cfg.index))
					REG_POS_LOWEST:     pos_lowest_q    <= cfg.data[POS_BITS-1:0];
					REG_POS_HIGHEST:    pos_highest_q   <= cfg.data[POS_BITS-1:0];
					REG_COARSE_STRIDE:  coarse_stride_q <= cfg.data[COARSE_W-1:0];
					REG_FINE_STRIDE:    fine_stride_q   <= cfg.data[FINE_STRIDE_W-1:0];
					REG_FINE_COUNT:     fine_count_q    <= cfg.data[FINE_COUNT_W-1:0];
					REG_SETTLE_WAIT:    settle_wait_q   <= cfg.data[SETTLE_W-1:0];
					REG_RECHECK_PERIOD: recheck_q       <= cfg.data[RECHECK_W-1:0];
					REG_DROP_PERCENT:   drop_q          <= cfg.data[DROP_W-1:0];
					default: ;
				endcase
			end

			if (item_in.valid && item_in.ready) begin
				v_s1     <= 1'b1;
				en_s1    <= item_in.af_enable;
				hold_s1  <= item_in.manual_hold;
				stat_s1  <= item_in.stat_new;
				sharp_s1 <= item_in.sharpness;
				lens_s1  <= item_in.lens_now;
				x100_s1  <= x100_in;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end

			if (adv) begin
				mode_q       <= mode_n;
				en_seen_q    <= en_seen_n;
				settle_q     <= settle_n;
				best_sharp_q <= best_sharp_n;
				best_lens_q  <= best_lens_n;
				fine_start_q <= fine_start_n;
				lock_sharp_q <= lock_sharp_n;
				lock_age_q   <= lock_age_n;
				last_q       <= last_n;
				if (lock_load)
					lock_prod_q <= mul_p;
			end else if (cfg_drop) begin
				// keep the drift threshold product in step with drop_percent
				lock_prod_q <= mul_p;
			end
		end
	end
endmodule

// ===== sv/contrast_autofocus_sweep_unit.sv =====
// Top level of the contrast autofocus sweep unit.
// Uses casu_pkg, the channel interfaces, casu_core and casu_out_buf.

// Takes one item per clock and gives exactly one result per item. An accepted
// item sits in the input register while its whole state update is worked out;
// when the output buffer has room, the result enters the two-entry output
// buffer, which presents results in order until each is taken. Items flow
// back to back as long as results are taken; the input stalls only while both
// buffer entries are full. Configuration writes are accepted on every cycle
// and must be made while no item is in flight; the drift threshold (locked
// sharpness times drop_percent) is kept as a stored product that is refreshed
// on lock and on a drop_percent write. Reset returns all limits and strides
// to their defaults and the search to off.
module contrast_autofocus_sweep_unit
	import casu_pkg::*;
#(
	parameter int POS_BITS   = 10,
	parameter int SHARP_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	casu_in_if.sink    item_in,
	casu_out_if.source result_out,
	casu_cfg_if.sink   cfg
);
	localparam int RES_W = POS_BITS + 1 + 2 + SHARP_BITS;

	logic                  res_push;
	logic                  buf_ready;
	logic [POS_BITS-1:0]   res_target;
	logic                  res_move;
	af_status_t            res_status;
	logic [SHARP_BITS-1:0] res_shown;
	logic [RES_W-1:0]      buf_out;

	casu_core #(
		.POS_BITS   (POS_BITS),
		.SHARP_BITS (SHARP_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_in),
		.cfg        (cfg),
		.res_push   (res_push),
		.buf_ready  (buf_ready),
		.res_target (res_target),
		.res_move   (res_move),
		.res_status (res_status),
		.res_shown  (res_shown)
	);

	casu_out_buf #(
		.W (RES_W)
	) u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_push),
		.push_data  ({res_target, res_move, res_status, res_shown}),
		.push_ready (buf_ready),
		.out_valid  (result_out.valid),
		.out_ready  (result_out.ready),
		.out_data   (buf_out)
	);

	assign result_out.lens_target     = buf_out[RES_W-1 -: POS_BITS];
	assign result_out.lens_move       = buf_out[SHARP_BITS+2];
	assign result_out.af_status       = buf_out[SHARP_BITS+1 -: 2];
	assign result_out.shown_sharpness = buf_out[SHARP_BITS-1:0];

	// a lens command only comes out of an active search or lock
	a_move_needs_search: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && result_out.lens_move) |->
			(result_out.af_status == ST_SEARCH || result_out.af_status == ST_LOCKED))
		else $error("lens move with status off or override");

	// input stalls only because the output buffer is full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_in.ready |-> !buf_ready)
		else $error("input stalled while output buffer has room");

	// a pushed result is visible on the next cycle
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> result_out.valid)
		else $error("pushed result not presented");
endmodule
